// File: rtl/core/nnps_pkg.sv
// Shared types and register indexes for the nearest neighbor plane scaler.
`timescale 1ns / 1ps

package nnps_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_DELIVER
    } state_t;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W   = 13;
    localparam int SRC_DIM_W    = 9;
    localparam int DST_DIM_W    = 13;
    localparam int PIXEL_W      = 8;

endpackage

// File: rtl/core/nearest_neighbor_plane_scaler.sv
// Nearest neighbor scaler for one 8-bit plane held in an on-chip frame store.
//
// Channels: item (action, pixel_in) with item_valid/item_ready, result
// (pixel_out, end_of_line, end_of_frame) with result_valid/result_ready, and a
// config write channel (cfg_index, cfg_data) with cfg_valid/cfg_ready that is
// always ready. A load beat (action 0) writes the next source pixel in raster
// order. An emit beat (action 1) yields one result beat. Emit steps: source
// coordinates come from a restoring divider that retires one quotient bit per
// cycle, QW = clog2(max source dimension) bits (8 at the defaults), then a
// frame store read and a load into the output register. The next item is
// taken as soon as the result sits in the output register, even if the
// receiver has not taken it. A stalled receiver holds the output register;
// a following emit waits in its last step until the register frees.
// Reset clears the counters, sets all sizes to 256 and leaves the frame
// store contents undefined; no clearing pass is run.
`timescale 1ns / 1ps

module nearest_neighbor_plane_scaler
    import nnps_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  action,
    input  logic [PIXEL_W-1:0]    pixel_in,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [PIXEL_W-1:0]    pixel_out,
    output logic                  end_of_line,
    output logic                  end_of_frame,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DWW   = $clog2(MAX_DST_DIM + 1);
    localparam int CW    = $clog2(MAX_DST_DIM);
    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT);
    localparam int QW    = (XW > YW) ? XW : YW;
    localparam int QCW   = $clog2(QW);
    localparam int DIVW  = DWW + QW;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    state_t state_reg, state_next;

    logic [SRC_DIM_W-1:0] src_width_reg, src_height_reg;
    logic [DST_DIM_W-1:0] dst_width_reg, dst_height_reg;

    logic [SWW-1:0] sw;
    logic [SHW-1:0] sh;
    logic [DWW-1:0] dw, dh;

    logic [XW-1:0] ld_col_reg;
    logic [YW-1:0] ld_row_reg;
    logic [CW-1:0] out_col_reg, out_row_reg;
    logic [CW-1:0] col_c, row_c;
    logic          eol_c, eof_c;

    logic [DIVW-1:0] rx_reg, ry_reg, dx_reg, dy_reg;
    logic [QW-1:0]   qx_reg, qy_reg;
    logic [QCW-1:0]  step_reg;
    logic            eol_reg, eof_reg;
    logic            ge_x, ge_y;

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic [AW-1:0]      wr_addr, rd_addr;

    logic result_valid_reg, result_valid_next;
    logic [PIXEL_W-1:0] pixel_out_reg;
    logic eol_out_reg, eof_out_reg;

    logic accept, load_beat, emit_beat;
    logic rd_en, div_en, out_load;

    // Size registers as seen by the datapath, saturated to their legal range.
    always_comb
    begin
        if (src_width_reg == '0)
            sw = SWW'(1);
        else if (src_width_reg > MAX_SRC_WIDTH)
            sw = SWW'(MAX_SRC_WIDTH);
        else
            sw = SWW'(src_width_reg);

        if (src_height_reg == '0)
            sh = SHW'(1);
        else if (src_height_reg > MAX_SRC_HEIGHT)
            sh = SHW'(MAX_SRC_HEIGHT);
        else
            sh = SHW'(src_height_reg);

        if (dst_width_reg == '0)
            dw = DWW'(1);
        else if (dst_width_reg > MAX_DST_DIM)
            dw = DWW'(MAX_DST_DIM);
        else
            dw = DWW'(dst_width_reg);

        if (dst_height_reg == '0)
            dh = DWW'(1);
        else if (dst_height_reg > MAX_DST_DIM)
            dh = DWW'(MAX_DST_DIM);
        else
            dh = DWW'(dst_height_reg);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_DIM_W'(256);
            src_height_reg <= SRC_DIM_W'(256);
            dst_width_reg  <= DST_DIM_W'(256);
            dst_height_reg <= DST_DIM_W'(256);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_DIM_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_DIM_W-1:0];
                CFG_DST_WIDTH:  dst_width_reg  <= cfg_data[DST_DIM_W-1:0];
                CFG_DST_HEIGHT: dst_height_reg <= cfg_data[DST_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept    = item_valid && item_ready;
    assign load_beat = accept && !action;
    assign emit_beat = accept && action;

    // Current destination position, pinned to the last one when past the size.
    always_comb
    begin
        col_c = (out_col_reg >= dw) ? CW'(dw - DWW'(1)) : out_col_reg;
        row_c = (out_row_reg >= dh) ? CW'(dh - DWW'(1)) : out_row_reg;
        eol_c = (DWW'(col_c) == dw - DWW'(1));
        eof_c = eol_c && (DWW'(row_c) == dh - DWW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_col_reg  <= '0;
            ld_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            if (load_beat)
            begin
                if (SWW'(ld_col_reg) + SWW'(1) >= sw)
                begin
                    ld_col_reg <= '0;
                    if (SHW'(ld_row_reg) + SHW'(1) >= sh)
                        ld_row_reg <= '0;
                    else
                        ld_row_reg <= ld_row_reg + YW'(1);
                end
                else
                    ld_col_reg <= ld_col_reg + XW'(1);
            end
            if (emit_beat)
            begin
                if (eol_c)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= eof_c ? '0 : row_c + CW'(1);
                end
                else
                begin
                    out_col_reg <= col_c + CW'(1);
                    out_row_reg <= row_c;
                end
            end
        end
    end

    // Restoring divider, one quotient bit per cycle for each axis.
    assign ge_x = (rx_reg >= dx_reg);
    assign ge_y = (ry_reg >= dy_reg);

    always_ff @(posedge clk)
    begin
        if (emit_beat)
        begin
            rx_reg   <= DIVW'(col_c) * DIVW'(sw);
            ry_reg   <= DIVW'(row_c) * DIVW'(sh);
            dx_reg   <= DIVW'(dw) << (QW - 1);
            dy_reg   <= DIVW'(dh) << (QW - 1);
            qx_reg   <= '0;
            qy_reg   <= '0;
            step_reg <= QCW'(QW - 1);
            eol_reg  <= eol_c;
            eof_reg  <= eof_c;
        end
        else if (div_en)
        begin
            rx_reg   <= ge_x ? rx_reg - dx_reg : rx_reg;
            ry_reg   <= ge_y ? ry_reg - dy_reg : ry_reg;
            dx_reg   <= dx_reg >> 1;
            dy_reg   <= dy_reg >> 1;
            qx_reg   <= {qx_reg[QW-2:0], ge_x};
            qy_reg   <= {qy_reg[QW-2:0], ge_y};
            step_reg <= step_reg - QCW'(1);
        end
    end

    assign wr_addr = AW'(ld_row_reg) * AW'(MAX_SRC_WIDTH) + AW'(ld_col_reg);
    assign rd_addr = AW'(qy_reg[YW-1:0]) * AW'(MAX_SRC_WIDTH) + AW'(qx_reg[XW-1:0]);

    always_ff @(posedge clk)
    begin
        if (load_beat)
            mem[wr_addr] <= pixel_in;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (emit_beat)
                    state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (step_reg == '0)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_DELIVER;
            ST_DELIVER:
                if (!result_valid_reg || result_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        div_en     = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:    item_ready = 1'b1;
            ST_DIVIDE:  div_en     = 1'b1;
            ST_READ:    rd_en      = 1'b1;
            ST_DELIVER: out_load   = !result_valid_reg || result_ready;
            default: ;
        endcase
    end

    always_comb
    begin
        if (out_load)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_out_reg <= rd_data_reg;
            eol_out_reg   <= eol_reg;
            eof_out_reg   <= eof_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign end_of_line  = eol_out_reg;
    assign end_of_frame = eof_out_reg;

endmodule
